@@ hw/rtl/dfd_pkg.sv @@
`default_nettype none

package dfd_pkg;

   localparam int MAX_POINTS_DEFAULT = 256;
   localparam int COORD_W            = 16;
   localparam int MAG_W              = 16;
   localparam int SQ_W               = 32;
   localparam int DIST_W             = 34;
   localparam int ROOT_W             = 17;
   localparam int REM_W              = 20;
   localparam int SQRT_STEPS         = 17;
   localparam int SQRT_CNT_W         = 5;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_MUL,
      ST_ADD,
      ST_WRITE,
      ST_SQRT_GO,
      ST_SQRT_WAIT
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // store the incoming point
      logic init;        // zero the row and column counters
      logic mul_en;      // square the coordinate differences
      logic add_en;      // sum squares, pick best predecessor
      logic wr_en;       // close the cell and write the row entry
      logic sqrt_start;  // launch the square root on the final cell
      logic err_out;     // load an error result and clear the curves
      logic ok_out;      // load the computed result and clear the curves
   } dfd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic overflow;
      logic empty;
      logic row_end;
      logic col_end;
      logic sqrt_done;
      logic rsp_full;
   } dfd_sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/discrete_frechet_distance_core.sv @@
`default_nettype none

// Discrete Frechet distance between two polylines P and Q.
// Input channel (req_*): one point per transaction, req_op selects P (0) or
// Q (1); coordinates are signed Q12.4. Points load at one per cycle while
// idle. A req_last transaction stores its point and starts the computation.
// Result channel (rsp_*): one transaction per req_last, carrying the squared
// distance (Q26.8), its floor square root (Q13.4) and a status code
// (ok, empty curve, store overflow). Both curves are cleared afterwards.
// From the closing point, one shared cell unit works through every table
// cell in the steps read, square, sum/min and max/write, and the square
// root then resolves one result bit per cycle. Error results are loaded
// from the check state into the result register.
// While the result waits for rsp_ready, further points are still accepted;
// only the next closing point is held off until the result is taken.
// Reset (synchronous, active high) empties both curves and drops any
// pending result; point stores are not cleared, only counted.
module discrete_frechet_distance_core #(
   parameter int MAX_POINTS = dfd_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_op,
   input  wire logic signed [dfd_pkg::COORD_W-1:0]  req_point_x,
   input  wire logic signed [dfd_pkg::COORD_W-1:0]  req_point_y,
   input  wire logic                                req_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic             [dfd_pkg::DIST_W-1:0]   rsp_dist_squared,
   output logic             [dfd_pkg::ROOT_W-1:0]   rsp_dist_res,
   output logic             [1:0]                   rsp_status
);

   dfd_pkg::dfd_cmd_type cmd;
   dfd_pkg::dfd_sts_type sts;

   // sequencing: load, check, cell walk, square root, result
   dfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // point stores, row buffer, cell unit, square root and result register
   dfd_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_op),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dist_squared (rsp_dist_squared),
      .rsp_dist_res     (rsp_dist_res),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire

@@ hw/rtl/dfd_isqrt.sv @@
`default_nettype none

module dfd_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [dfd_pkg::DIST_W-1:0]    value,
   output logic                               done,
   output logic      [dfd_pkg::ROOT_W-1:0]    root
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [dfd_pkg::SQRT_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [dfd_pkg::DIST_W-1:0]        val_ff, val_in;
   logic [dfd_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [dfd_pkg::ROOT_W-1:0]        root_ff, root_in;
   logic [dfd_pkg::REM_W-1:0]         rem_sh;
   logic [dfd_pkg::REM_W-1:0]         trial;

   // bring down two bits per step, one result bit per step
   assign rem_sh = {rem_ff[dfd_pkg::REM_W-3:0], val_ff[dfd_pkg::DIST_W-1 -: 2]};
   assign trial  = dfd_pkg::REM_W'({root_ff, 2'b01});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = dfd_pkg::SQRT_CNT_W'(dfd_pkg::SQRT_STEPS - 1);
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = val_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[dfd_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[dfd_pkg::ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

@@ hw/rtl/dfd_dpath.sv @@
`default_nettype none

module dfd_dpath #(
   parameter int MAX_POINTS = dfd_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire dfd_pkg::dfd_cmd_type                cmd,
   output dfd_pkg::dfd_sts_type                     sts,
   input  wire logic                                req_op,
   input  wire logic signed [dfd_pkg::COORD_W-1:0]  req_point_x,
   input  wire logic signed [dfd_pkg::COORD_W-1:0]  req_point_y,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic             [dfd_pkg::DIST_W-1:0]   rsp_dist_squared,
   output logic             [dfd_pkg::ROOT_W-1:0]   rsp_dist_res,
   output logic             [1:0]                   rsp_status
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int PW = 2 * dfd_pkg::COORD_W;

   // point stores, x in the upper half, y in the lower half
   logic [PW-1:0]             p_mem [MAX_POINTS];
   logic [PW-1:0]             q_mem [MAX_POINTS];
   logic [dfd_pkg::DIST_W-1:0] row_mem [MAX_POINTS];

   logic [PW-1:0]              p_rd_ff;
   logic [PW-1:0]              q_rd_ff;
   logic [dfd_pkg::DIST_W-1:0] up_rd_ff;

   logic [CW-1:0]              p_count_ff, p_count_in;
   logic [CW-1:0]              q_count_ff, q_count_in;
   logic                       overflow_ff, overflow_in;
   logic [AW-1:0]              i_ff, i_in;
   logic [AW-1:0]              j_ff, j_in;

   logic [dfd_pkg::SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [dfd_pkg::DIST_W-1:0] dist_ff, best_ff, left_ff, diag_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dfd_pkg::DIST_W-1:0] rsp_dsq_ff;
   logic [dfd_pkg::ROOT_W-1:0] rsp_res_ff;
   logic [1:0]                 rsp_status_ff;

   logic                       p_full, q_full;
   logic [dfd_pkg::COORD_W:0]  dx, dy;
   logic [dfd_pkg::MAG_W-1:0]  mag_x, mag_y;
   logic [dfd_pkg::DIST_W-1:0] best_c, min_ud, min_all, cell_c;
   logic                       first_row, first_col;
   logic                       sqrt_done;
   logic [dfd_pkg::ROOT_W-1:0] sqrt_root;

   assign p_full = (p_count_ff == CW'(MAX_POINTS));
   assign q_full = (q_count_ff == CW'(MAX_POINTS));

   // point load and count bookkeeping
   always_comb begin
      p_count_in  = p_count_ff;
      q_count_in  = q_count_ff;
      overflow_in = overflow_ff;
      if (cmd.err_out || cmd.ok_out) begin
         p_count_in  = '0;
         q_count_in  = '0;
         overflow_in = 1'b0;
      end else if (cmd.load) begin
         if (!req_op) begin
            if (p_full) overflow_in = 1'b1;
            else        p_count_in  = p_count_ff + 1'b1;
         end else begin
            if (q_full) overflow_in = 1'b1;
            else        q_count_in  = q_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !req_op && !p_full) begin
         p_mem[p_count_ff[AW-1:0]] <= {req_point_x, req_point_y};
      end
      if (cmd.load && req_op && !q_full) begin
         q_mem[q_count_ff[AW-1:0]] <= {req_point_x, req_point_y};
      end
      if (cmd.wr_en) begin
         row_mem[j_ff] <= cell_c;
      end
      p_rd_ff  <= p_mem[i_ff];
      q_rd_ff  <= q_mem[j_ff];
      up_rd_ff <= row_mem[j_ff];
   end

   // cell walk: j across Q, then i down P
   assign sts.row_end = (CW'(j_ff) == q_count_ff - 1'b1);
   assign sts.col_end = (CW'(i_ff) == p_count_ff - 1'b1);

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      if (cmd.init) begin
         i_in = '0;
         j_in = '0;
      end else if (cmd.wr_en) begin
         if (sts.row_end) begin
            j_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   // squared distance of the current cell
   assign dx = {p_rd_ff[PW-1], p_rd_ff[PW-1 -: dfd_pkg::COORD_W]}
             - {q_rd_ff[PW-1], q_rd_ff[PW-1 -: dfd_pkg::COORD_W]};
   assign dy = {p_rd_ff[dfd_pkg::COORD_W-1], p_rd_ff[dfd_pkg::COORD_W-1:0]}
             - {q_rd_ff[dfd_pkg::COORD_W-1], q_rd_ff[dfd_pkg::COORD_W-1:0]};
   assign mag_x = dx[dfd_pkg::COORD_W] ? dfd_pkg::MAG_W'(-dx) : dx[dfd_pkg::MAG_W-1:0];
   assign mag_y = dy[dfd_pkg::COORD_W] ? dfd_pkg::MAG_W'(-dy) : dy[dfd_pkg::MAG_W-1:0];

   // best predecessor; edges of the table have only one, the first cell none
   assign first_row = (i_ff == '0);
   assign first_col = (j_ff == '0);
   assign min_ud    = (up_rd_ff < diag_ff) ? up_rd_ff : diag_ff;
   assign min_all   = (min_ud < left_ff) ? min_ud : left_ff;

   always_comb begin
      if (first_row && first_col) best_c = '0;
      else if (first_row)         best_c = left_ff;
      else if (first_col)         best_c = up_rd_ff;
      else                        best_c = min_all;
   end

   assign cell_c = (best_ff > dist_ff) ? best_ff : dist_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         sqx_ff <= dfd_pkg::SQ_W'(mag_x) * dfd_pkg::SQ_W'(mag_x);
         sqy_ff <= dfd_pkg::SQ_W'(mag_y) * dfd_pkg::SQ_W'(mag_y);
      end
      if (cmd.add_en) begin
         dist_ff <= dfd_pkg::DIST_W'(sqx_ff) + dfd_pkg::DIST_W'(sqy_ff);
         best_ff <= best_c;
      end
      if (cmd.wr_en) begin
         left_ff <= cell_c;
         diag_ff <= up_rd_ff;
      end
   end

   dfd_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value (left_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.err_out || cmd.ok_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.err_out) begin
         rsp_dsq_ff    <= '0;
         rsp_res_ff    <= '0;
         rsp_status_ff <= overflow_ff ? dfd_pkg::STATUS_OVERFLOW : dfd_pkg::STATUS_EMPTY;
      end else if (cmd.ok_out) begin
         rsp_dsq_ff    <= left_ff;
         rsp_res_ff    <= sqrt_root;
         rsp_status_ff <= dfd_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_count_ff   <= '0;
         q_count_ff   <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_count_ff   <= p_count_in;
         q_count_ff   <= q_count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
   end

   assign sts.overflow  = overflow_ff;
   assign sts.empty     = (p_count_ff == '0) || (q_count_ff == '0);
   assign sts.sqrt_done = sqrt_done;
   assign sts.rsp_full  = rsp_valid_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dist_squared = rsp_dsq_ff;
   assign rsp_dist_res     = rsp_res_ff;
   assign rsp_status       = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (p_count_ff <= CW'(MAX_POINTS)) && (q_count_ff <= CW'(MAX_POINTS)))
      else $error("point count beyond store depth");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.err_out || cmd.ok_out) |=> (p_count_ff == '0) && (q_count_ff == '0) && !overflow_ff)
      else $error("curves not cleared after result");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (cmd.ok_out || cmd.err_out) |=> rsp_valid_ff)
      else $error("result register not loaded");

endmodule

`default_nettype wire

@@ hw/rtl/dfd_ctrl.sv @@
`default_nettype none

module dfd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_last,
   output logic                       req_ready,
   input  wire dfd_pkg::dfd_sts_type  sts,
   output dfd_pkg::dfd_cmd_type       cmd
);

   dfd_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfd_pkg::ST_IDLE: begin
            if (req_valid && req_ready && req_last) state_in = dfd_pkg::ST_CHECK;
         end
         dfd_pkg::ST_CHECK: begin
            if (sts.overflow || sts.empty) state_in = dfd_pkg::ST_IDLE;
            else                           state_in = dfd_pkg::ST_READ;
         end
         dfd_pkg::ST_READ:  state_in = dfd_pkg::ST_MUL;
         dfd_pkg::ST_MUL:   state_in = dfd_pkg::ST_ADD;
         dfd_pkg::ST_ADD:   state_in = dfd_pkg::ST_WRITE;
         dfd_pkg::ST_WRITE: begin
            if (sts.row_end && sts.col_end) state_in = dfd_pkg::ST_SQRT_GO;
            else                            state_in = dfd_pkg::ST_READ;
         end
         dfd_pkg::ST_SQRT_GO: state_in = dfd_pkg::ST_SQRT_WAIT;
         dfd_pkg::ST_SQRT_WAIT: begin
            if (sts.sqrt_done) state_in = dfd_pkg::ST_IDLE;
         end
         default: state_in = dfd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         dfd_pkg::ST_IDLE: begin
            // a closing point waits until the previous result is taken
            req_ready = !(sts.rsp_full && req_last);
            cmd.load  = req_valid && req_ready;
         end
         dfd_pkg::ST_CHECK: begin
            cmd.err_out = sts.overflow || sts.empty;
            cmd.init    = !(sts.overflow || sts.empty);
         end
         dfd_pkg::ST_READ:      cmd = '0;
         dfd_pkg::ST_MUL:       cmd.mul_en = 1'b1;
         dfd_pkg::ST_ADD:       cmd.add_en = 1'b1;
         dfd_pkg::ST_WRITE:     cmd.wr_en = 1'b1;
         dfd_pkg::ST_SQRT_GO:   cmd.sqrt_start = 1'b1;
         dfd_pkg::ST_SQRT_WAIT: cmd.ok_out = sts.sqrt_done;
         default:               cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.ok_out || cmd.err_out) |-> !sts.rsp_full)
      else $error("result register overwritten");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == dfd_pkg::ST_IDLE))
      else $error("point stored during computation");

   a_write_after_add: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> $past(cmd.add_en))
      else $error("cell written without its sum stage");

endmodule

`default_nettype wire
